>>> rtl/core/rmc_pkg.sv
// Shared types, constants and helpers for the median-counter rumor block.
// Depends on nothing; every other file in rtl/core imports it.
package rmc_pkg;

    localparam int ROUND_BITS = 10;
    localparam int MEMBER_W   = 6;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        FUNC_RECV  = 2'd0,
        FUNC_PEER  = 2'd1,
        FUNC_ADV   = 2'd2,
        FUNC_START = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        PH_NEW   = 2'd0,
        PH_KNOWN = 2'd1,
        PH_OLD   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        SEED_NONE  = 2'd0,
        SEED_OLD   = 2'd1,
        SEED_KNOWN = 2'd2,
        SEED_ENTRY = 2'd3
    } seed_t;

    typedef enum logic [2:0] {
        BK_IDLE = 3'd0,
        BK_EXEC = 3'd1,
        BK_SCAN = 3'd2,
        BK_TAIL = 3'd3,
        BK_FIN  = 3'd4
    } back_state_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IN_B  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IN_C  = 2'd2;

    typedef struct packed {
        logic [ROUND_BITS-1:0] max_total;
        logic [ROUND_BITS-1:0] max_b;
        logic [ROUND_BITS-1:0] max_c;
    } cfg_t;

    typedef struct packed {
        func_t                 func;
        logic                  in_range;
        logic [MEMBER_W-1:0]   member;
        logic [ROUND_BITS-1:0] round;
        seed_t                 seed;
    } cmd_t;

    function automatic logic [ROUND_BITS-1:0] sat_round(input logic [ROUND_BITS:0] v);
        sat_round = v[ROUND_BITS] ? {ROUND_BITS{1'b1}} : v[ROUND_BITS-1:0];
    endfunction

endpackage

>>> rtl/core/rumor_median_counter_fsm.sv
// Median-counter rumor state machine with phases new, known and old.
// Input channel in_valid/in_stall carries func, member, round, with_sender;
// one result beat per input beat on out_valid/out_stall carries phase,
// round_count, spread_rounds, known_rounds and is_old, showing the state
// after the item. Results come out in input order.
// Path: receive, peer, start and an advance outside the new phase pass the
// queue, the back end's pop and execute steps and the result register; an
// advance in the new phase within the total limit instead walks the member
// table one entry a cycle (scan, tail, final update) before its result.
// The back end takes one item at a time; a new-phase table walk occupies it.
// A two-entry command queue sits between decode and execution, so up to three
// items are taken while a result waits on out_stall: one held in execution
// and two in the queue.
// Reset: phase new, counters zero, table and pending peers empty, limits
// 10 / 3 / 3; no clearing pass, items are taken right after reset.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index (0 total,
// 1 spreading, 2 known limit); the user writes only while the block is idle,
// not enforced. Depends on rmc_pkg, rmc_front, rmc_queue, rmc_back.
module rumor_median_counter_fsm #(
    parameter int MEMBERS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [rmc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rmc_pkg::ROUND_BITS-1:0]  cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      func,
    input  logic [rmc_pkg::MEMBER_W-1:0]    member,
    input  logic [rmc_pkg::ROUND_BITS-1:0]  round,
    input  logic                            with_sender,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      phase,
    output logic [rmc_pkg::ROUND_BITS-1:0]  round_count,
    output logic [rmc_pkg::ROUND_BITS-1:0]  spread_rounds,
    output logic [rmc_pkg::ROUND_BITS-1:0]  known_rounds,
    output logic                            is_old
);
    import rmc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    cmd_t front_cmd;
    cmd_t head_cmd;
    logic head_valid;
    logic pop;
    logic full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MAX_TOTAL: cfg_next.max_total = cfg_wdata;
                CFG_MAX_IN_B:  cfg_next.max_b     = cfg_wdata;
                CFG_MAX_IN_C:  cfg_next.max_c     = cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.max_total <= ROUND_BITS'(10);
            cfg_reg.max_b     <= ROUND_BITS'(3);
            cfg_reg.max_c     <= ROUND_BITS'(3);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_stall = full;

    rmc_front #(
        .MEMBERS (MEMBERS)
    ) u_front (
        .func        (func),
        .member      (member),
        .round       (round),
        .with_sender (with_sender),
        .cfg         (cfg_reg),
        .cmd         (front_cmd)
    );

    rmc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid),
        .push_cmd   (front_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    rmc_back #(
        .MEMBERS (MEMBERS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .phase         (phase),
        .round_count   (round_count),
        .spread_rounds (spread_rounds),
        .known_rounds  (known_rounds),
        .is_old        (is_old)
    );

endmodule

>>> rtl/core/rmc_front.sv
// Front end: decodes one input beat into a command for the back end.
// Depends on rmc_pkg; feeds rmc_queue.
module rmc_front #(
    parameter int MEMBERS = 64
) (
    input  logic [1:0]                    func,
    input  logic [rmc_pkg::MEMBER_W-1:0]  member,
    input  logic [rmc_pkg::ROUND_BITS-1:0] round,
    input  logic                          with_sender,
    input  rmc_pkg::cfg_t                 cfg,
    output rmc_pkg::cmd_t                 cmd
);
    import rmc_pkg::*;

    logic in_range;

    assign in_range = (32'(member) < MEMBERS);

    always_comb
    begin
        cmd.func     = func_t'(func);
        cmd.in_range = in_range;
        cmd.member   = member;
        cmd.round    = round;
        if (!with_sender) begin
            cmd.seed = SEED_NONE;
        end else if (round > cfg.max_total) begin
            cmd.seed = SEED_OLD;
        end else if (round > cfg.max_b) begin
            cmd.seed = (cfg.max_c == '0) ? SEED_OLD : SEED_KNOWN;
        end else if (in_range) begin
            cmd.seed = SEED_ENTRY;
        end else begin
            cmd.seed = SEED_NONE;
        end
    end

endmodule

>>> rtl/core/rmc_queue.sv
// Two-entry command queue between front end and back end.
// Depends on rmc_pkg for the command type.
module rmc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rmc_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output rmc_pkg::cmd_t head_cmd
);
    import rmc_pkg::*;

    cmd_t       ent_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = ent_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/core/rmc_back.sv
// Back end: executes commands against the member table and round counters,
// walks the table on an advance in the new phase. Depends on rmc_pkg.
module rmc_back #(
    parameter int MEMBERS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rmc_pkg::cfg_t                  cfg,
    input  logic                           head_valid,
    input  rmc_pkg::cmd_t                  head_cmd,
    output logic                           pop,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic [1:0]                     phase,
    output logic [rmc_pkg::ROUND_BITS-1:0] round_count,
    output logic [rmc_pkg::ROUND_BITS-1:0] spread_rounds,
    output logic [rmc_pkg::ROUND_BITS-1:0] known_rounds,
    output logic                           is_old
);
    import rmc_pkg::*;

    localparam int IDX_W = (MEMBERS > 1) ? $clog2(MEMBERS) : 1;
    localparam int CNT_W = $clog2(MEMBERS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEMBERS - 1);

    back_state_t           state_reg;
    back_state_t           state_next;
    cmd_t                  cmd_reg;
    cmd_t                  cmd_next;
    phase_t                phase_reg;
    phase_t                phase_next;
    logic [ROUND_BITS-1:0] total_reg;
    logic [ROUND_BITS-1:0] total_next;
    logic [ROUND_BITS-1:0] spread_reg;
    logic [ROUND_BITS-1:0] spread_next;
    logic [ROUND_BITS-1:0] known_reg;
    logic [ROUND_BITS-1:0] known_next;
    logic [MEMBERS-1:0]    member_valid_reg;
    logic [MEMBERS-1:0]    member_valid_next;
    logic [MEMBERS-1:0]    pending_peer_reg;
    logic [MEMBERS-1:0]    pending_peer_next;
    logic [IDX_W-1:0]      scan_reg;
    logic [IDX_W-1:0]      scan_next;
    logic                  chk_vld_reg;
    logic                  chk_vld_next;
    logic [IDX_W-1:0]      chk_idx_reg;
    logic [IDX_W-1:0]      chk_idx_next;
    logic [CNT_W-1:0]      less_reg;
    logic [CNT_W-1:0]      less_next;
    logic [CNT_W-1:0]      ge_reg;
    logic [CNT_W-1:0]      ge_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ROUND_BITS-1:0] rdata_reg;
    logic [ROUND_BITS-1:0] round_mem [MEMBERS];

    logic [MEMBER_W+IDX_W-1:0] head_wide;
    logic [MEMBER_W+IDX_W-1:0] cmd_wide;
    logic [IDX_W-1:0]          head_idx;
    logic [IDX_W-1:0]          cmd_idx;
    logic [IDX_W-1:0]          rd_addr;
    logic                      mem_we;
    logic                      out_free;
    logic [ROUND_BITS:0]       total_inc;
    logic [ROUND_BITS:0]       spread_inc;
    logic [ROUND_BITS:0]       spread_fin;
    logic [ROUND_BITS:0]       known_inc;
    logic                      new_over;
    logic                      entry_on;
    logic [ROUND_BITS-1:0]     entry_round;
    logic                      known_now;

    assign head_wide  = {{IDX_W{1'b0}}, head_cmd.member};
    assign cmd_wide   = {{IDX_W{1'b0}}, cmd_reg.member};
    assign head_idx   = head_wide[IDX_W-1:0];
    assign cmd_idx    = cmd_wide[IDX_W-1:0];
    assign out_free   = !out_valid_reg || !out_stall;
    assign total_inc  = {1'b0, total_reg} + 1'b1;
    assign spread_inc = {1'b0, spread_reg} + 1'b1;
    assign known_inc  = {1'b0, known_reg} + 1'b1;
    assign new_over   = total_inc > {1'b0, cfg.max_total};
    assign spread_fin = (ge_reg > less_reg) ? spread_inc + 1'b1 : spread_inc;
    assign known_now  = hit_reg || (spread_fin > {1'b0, cfg.max_b});

    assign out_valid     = out_valid_reg;
    assign phase         = phase_reg;
    assign round_count   = total_reg;
    assign spread_rounds = spread_reg;
    assign known_rounds  = known_reg;
    assign is_old        = (phase_reg == PH_OLD);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head_valid) begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (cmd_reg.func == FUNC_ADV && phase_reg == PH_NEW && !new_over) begin
                    state_next = BK_SCAN;
                end else if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            BK_SCAN:
            begin
                if (scan_reg == LAST_IDX) begin
                    state_next = BK_TAIL;
                end
            end
            BK_TAIL:
            begin
                state_next = BK_FIN;
            end
            BK_FIN:
            begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next          = cmd_reg;
        phase_next        = phase_reg;
        total_next        = total_reg;
        spread_next       = spread_reg;
        known_next        = known_reg;
        member_valid_next = member_valid_reg;
        pending_peer_next = pending_peer_reg;
        scan_next         = scan_reg;
        chk_vld_next      = 1'b0;
        chk_idx_next      = chk_idx_reg;
        less_next         = less_reg;
        ge_next           = ge_reg;
        hit_next          = hit_reg;
        out_valid_next    = out_valid_reg && out_stall;
        pop               = 1'b0;
        mem_we            = 1'b0;
        rd_addr           = cmd_idx;

        // classify the entry read out of the table last cycle
        entry_on    = member_valid_reg[chk_idx_reg] || pending_peer_reg[chk_idx_reg];
        entry_round = member_valid_reg[chk_idx_reg] ? rdata_reg : '0;
        if (chk_vld_reg && entry_on) begin
            if ({1'b0, entry_round} < total_inc) begin
                less_next = less_reg + 1'b1;
            end else if (entry_round > cfg.max_b) begin
                hit_next = 1'b1;
            end else begin
                ge_next = ge_reg + 1'b1;
            end
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                rd_addr = head_idx;
                if (head_valid) begin
                    pop      = 1'b1;
                    cmd_next = head_cmd;
                end
            end
            BK_EXEC:
            begin
                unique case (cmd_reg.func)
                    FUNC_RECV:
                    begin
                        if (out_free) begin
                            out_valid_next = 1'b1;
                            if (phase_reg == PH_NEW && cmd_reg.in_range) begin
                                if (!member_valid_reg[cmd_idx] || rdata_reg < cmd_reg.round) begin
                                    mem_we = 1'b1;
                                end
                                member_valid_next[cmd_idx] = 1'b1;
                            end
                        end
                    end
                    FUNC_PEER:
                    begin
                        if (out_free) begin
                            out_valid_next = 1'b1;
                            if (cmd_reg.in_range) begin
                                pending_peer_next[cmd_idx] = 1'b1;
                            end
                        end
                    end
                    FUNC_ADV:
                    begin
                        unique case (phase_reg)
                            PH_NEW:
                            begin
                                if (!new_over) begin
                                    scan_next = '0;
                                    less_next = '0;
                                    ge_next   = '0;
                                    hit_next  = 1'b0;
                                end else if (out_free) begin
                                    out_valid_next    = 1'b1;
                                    phase_next        = PH_OLD;
                                    spread_next       = sat_round(spread_inc);
                                    member_valid_next = '0;
                                    pending_peer_next = '0;
                                end
                            end
                            PH_KNOWN:
                            begin
                                if (out_free) begin
                                    out_valid_next    = 1'b1;
                                    pending_peer_next = '0;
                                    if (new_over || known_inc > {1'b0, cfg.max_c}) begin
                                        phase_next        = PH_OLD;
                                        member_valid_next = '0;
                                    end else begin
                                        total_next = sat_round(total_inc);
                                        known_next = sat_round(known_inc);
                                    end
                                end
                            end
                            default:
                            begin
                                if (out_free) begin
                                    out_valid_next    = 1'b1;
                                    pending_peer_next = '0;
                                    total_next        = sat_round(total_inc);
                                end
                            end
                        endcase
                    end
                    FUNC_START:
                    begin
                        if (out_free) begin
                            out_valid_next    = 1'b1;
                            phase_next        = PH_NEW;
                            total_next        = '0;
                            spread_next       = '0;
                            known_next        = '0;
                            member_valid_next = '0;
                            pending_peer_next = '0;
                            unique case (cmd_reg.seed)
                                SEED_OLD:
                                begin
                                    phase_next = PH_OLD;
                                end
                                SEED_KNOWN:
                                begin
                                    phase_next = PH_KNOWN;
                                    known_next = ROUND_BITS'(1);
                                end
                                SEED_ENTRY:
                                begin
                                    mem_we                     = 1'b1;
                                    member_valid_next[cmd_idx] = 1'b1;
                                end
                                SEED_NONE:
                                begin
                                end
                            endcase
                        end
                    end
                endcase
            end
            BK_SCAN:
            begin
                rd_addr      = scan_reg;
                chk_vld_next = 1'b1;
                chk_idx_next = scan_reg;
                scan_next    = scan_reg + 1'b1;
            end
            BK_TAIL:
            begin
                rd_addr = scan_reg;
            end
            BK_FIN:
            begin
                if (out_free) begin
                    out_valid_next    = 1'b1;
                    total_next        = sat_round(total_inc);
                    member_valid_next = '0;
                    pending_peer_next = '0;
                    if (known_now) begin
                        phase_next  = PH_KNOWN;
                        known_next  = sat_round(known_inc);
                        spread_next = sat_round(spread_fin - 1'b1);
                    end else begin
                        spread_next = sat_round(spread_fin);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= BK_IDLE;
            phase_reg        <= PH_NEW;
            total_reg        <= '0;
            spread_reg       <= '0;
            known_reg        <= '0;
            member_valid_reg <= '0;
            pending_peer_reg <= '0;
            scan_reg         <= '0;
            chk_vld_reg      <= 1'b0;
            chk_idx_reg      <= '0;
            less_reg         <= '0;
            ge_reg           <= '0;
            hit_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            total_reg        <= total_next;
            spread_reg       <= spread_next;
            known_reg        <= known_next;
            member_valid_reg <= member_valid_next;
            pending_peer_reg <= pending_peer_next;
            scan_reg         <= scan_next;
            chk_vld_reg      <= chk_vld_next;
            chk_idx_reg      <= chk_idx_next;
            less_reg         <= less_next;
            ge_reg           <= ge_next;
            hit_reg          <= hit_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            round_mem[cmd_idx] <= cmd_reg.round;
        end
        rdata_reg <= round_mem[rd_addr];
    end

endmodule

>>> rtl/core/rmc_checker.sv
// Port-level checks for rumor_median_counter_fsm, bound to the top level.
// Depends on rmc_pkg for phase codes.
module rmc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [1:0]                     phase,
    input logic [rmc_pkg::ROUND_BITS-1:0] round_count,
    input logic [rmc_pkg::ROUND_BITS-1:0] spread_rounds,
    input logic [rmc_pkg::ROUND_BITS-1:0] known_rounds,
    input logic                           is_old
);
    import rmc_pkg::*;

    a_old_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_old == (phase == PH_OLD)))
        else $error("is_old disagrees with phase");

    a_new_no_known: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && phase == PH_NEW) |-> (known_rounds == '0))
        else $error("known rounds counted in new phase");

    a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (phase == PH_NEW || phase == PH_KNOWN || phase == PH_OLD))
        else $error("phase code out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(phase)
            && $stable(round_count) && $stable(spread_rounds)
            && $stable(known_rounds)))
        else $error("stalled result changed");

endmodule

bind rumor_median_counter_fsm rmc_checker u_rmc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .phase         (phase),
    .round_count   (round_count),
    .spread_rounds (spread_rounds),
    .known_rounds  (known_rounds),
    .is_old        (is_old)
);

>>> tb/rmc_rumor_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the median-counter rumor block: tracks config writes, predicts one
// report per accepted input beat and checks output beats in order. Depends on rmc_pkg.
module rmc_rumor_checker #(
    parameter int MEMBERS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [rmc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rmc_pkg::ROUND_BITS-1:0]  cfg_wdata,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [1:0]                      func,
    input  logic [rmc_pkg::MEMBER_W-1:0]    member,
    input  logic [rmc_pkg::ROUND_BITS-1:0]  round,
    input  logic                            with_sender,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [1:0]                      phase,
    input  logic [rmc_pkg::ROUND_BITS-1:0]  round_count,
    input  logic [rmc_pkg::ROUND_BITS-1:0]  spread_rounds,
    input  logic [rmc_pkg::ROUND_BITS-1:0]  known_rounds,
    input  logic                            is_old,
    output int                              fails,
    output int                              pending
);
    import rmc_pkg::*;

    localparam int RMAX = (1 << ROUND_BITS) - 1;

    typedef struct packed {
        phase_t                ph;
        logic [ROUND_BITS-1:0] total;
        logic [ROUND_BITS-1:0] spread;
        logic [ROUND_BITS-1:0] known;
        logic                  old;
    } rumor_report_t;

    rumor_report_t         awaited_reports[$];
    logic [ROUND_BITS-1:0] lim_total, lim_b, lim_c;
    phase_t                st_phase;
    int                    st_total, st_spread, st_known;
    logic [ROUND_BITS-1:0] tbl_round [MEMBERS];
    logic [MEMBERS-1:0]    tbl_valid;
    logic [MEMBERS-1:0]    peer_mark;

    function automatic int clip_round(int v);
        if (v < 0)
        begin
            return 0;
        end
        if (v > RMAX)
        begin
            return RMAX;
        end
        return v;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        fails++;
        if (fails <= 40)
        begin
            $display("%0t ns mismatch on %s: got %0d, want %0d", $time, what, got, want);
        end
    endtask

    task automatic known_round(inout int t, inout int c);
        c++;
        st_phase = PH_KNOWN;
        if (t > int'(lim_total) || c > int'(lim_c))
        begin
            c--;
            t--;
            st_phase = PH_OLD;
            tbl_valid = '0;
        end
    endtask

    task automatic spread_round(inout int t, inout int b, inout int c);
        int below;
        int at_or_above;
        int r;
        below = 0;
        at_or_above = 0;
        b++;
        if (t > int'(lim_total))
        begin
            t--;
            st_phase = PH_OLD;
            tbl_valid = '0;
            return;
        end
        for (int i = 0; i < MEMBERS; i++)
        begin
            if (!tbl_valid[i] && !peer_mark[i])
            begin
                continue;
            end
            r = tbl_valid[i] ? int'(tbl_round[i]) : 0;
            if (r < t)
            begin
                below++;
            end
            else if (r > int'(lim_b))
            begin
                st_phase = PH_KNOWN;
            end
            else
            begin
                at_or_above++;
            end
        end
        if (at_or_above > below)
        begin
            b++;
        end
        if (b > int'(lim_b))
        begin
            st_phase = PH_KNOWN;
        end
        if (st_phase == PH_KNOWN)
        begin
            c++;
            b--;
        end
        tbl_valid = '0;
    endtask

    task automatic predict_report(input logic [1:0] f, input logic [MEMBER_W-1:0] m,
                                  input logic [ROUND_BITS-1:0] rnd, input logic seeded,
                                  output rumor_report_t res);
        int t;
        int b;
        int c;
        t = st_total;
        b = st_spread;
        c = st_known;
        case (func_t'(f))
            FUNC_RECV:
            begin
                if (st_phase == PH_NEW)
                begin
                    if (!tbl_valid[m] || tbl_round[m] < rnd)
                    begin
                        tbl_round[m] = rnd;
                    end
                    tbl_valid[m] = 1'b1;
                end
            end
            FUNC_PEER:
            begin
                peer_mark[m] = 1'b1;
            end
            FUNC_ADV:
            begin
                t++;
                if (st_phase == PH_NEW)
                begin
                    spread_round(t, b, c);
                end
                else if (st_phase == PH_KNOWN)
                begin
                    known_round(t, c);
                end
                peer_mark = '0;
            end
            default:
            begin
                st_phase = PH_NEW;
                t = 0;
                b = 0;
                c = 0;
                tbl_valid = '0;
                peer_mark = '0;
                if (seeded)
                begin
                    if (rnd > lim_total)
                    begin
                        st_phase = PH_OLD;
                    end
                    else if (rnd > lim_b)
                    begin
                        known_round(t, c);
                    end
                    else
                    begin
                        tbl_round[m] = rnd;
                        tbl_valid[m] = 1'b1;
                    end
                end
            end
        endcase
        st_total = clip_round(t);
        st_spread = clip_round(b);
        st_known = clip_round(c);
        res.ph = st_phase;
        res.total = st_total[ROUND_BITS-1:0];
        res.spread = st_spread[ROUND_BITS-1:0];
        res.known = st_known[ROUND_BITS-1:0];
        res.old = (st_phase == PH_OLD);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rumor_report_t got;
        rumor_report_t want;
        if (!rst_n)
        begin
            fails = 0;
            lim_total = 10'd10;
            lim_b = 10'd3;
            lim_c = 10'd3;
            st_phase = PH_NEW;
            st_total = 0;
            st_spread = 0;
            st_known = 0;
            tbl_valid = '0;
            peer_mark = '0;
            awaited_reports.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.ph = phase_t'(phase);
                got.total = round_count;
                got.spread = spread_rounds;
                got.known = known_rounds;
                got.old = is_old;
                if (awaited_reports.size() == 0)
                begin
                    flag_mismatch("unexpected report beat", 1, 0);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (got.ph !== want.ph)
                    begin
                        flag_mismatch("phase", int'(got.ph), int'(want.ph));
                    end
                    if (got.total !== want.total)
                    begin
                        flag_mismatch("round_count", int'(got.total), int'(want.total));
                    end
                    if (got.spread !== want.spread)
                    begin
                        flag_mismatch("spread_rounds", int'(got.spread), int'(want.spread));
                    end
                    if (got.known !== want.known)
                    begin
                        flag_mismatch("known_rounds", int'(got.known), int'(want.known));
                    end
                    if (got.old !== want.old)
                    begin
                        flag_mismatch("is_old", int'(got.old), int'(want.old));
                    end
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MAX_TOTAL: lim_total = cfg_wdata;
                    CFG_MAX_IN_B:  lim_b = cfg_wdata;
                    CFG_MAX_IN_C:  lim_c = cfg_wdata;
                    default:       ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                predict_report(func, member, round, with_sender, want);
                awaited_reports.push_back(want);
            end
        end
        pending = awaited_reports.size();
    end

endmodule

>>> tb/tb_rumor_median_counter_fsm.sv
`timescale 1ns / 100ps
// Top of the rumor block testbench: clock, reset, config phases and item traffic
// with sender gaps and receiver stalls. Depends on rmc_pkg and rmc_rumor_checker.
module tb_rumor_median_counter_fsm;
    import rmc_pkg::*;

    localparam int MEMBERS = 64;
    localparam int SETTLE_CYCLES = MEMBERS + 8;
    localparam int ITEMS_PER_PHASE = 20;
    localparam int SATURATE_ADVANCES = 1030;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MAX_TOTAL;
    logic [ROUND_BITS-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            func = FUNC_RECV;
    logic [MEMBER_W-1:0]   member = '0;
    logic [ROUND_BITS-1:0] round = '0;
    logic                  with_sender = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            phase;
    logic [ROUND_BITS-1:0] round_count;
    logic [ROUND_BITS-1:0] spread_rounds;
    logic [ROUND_BITS-1:0] known_rounds;
    logic                  is_old;
    int                    fails;
    int                    pending;
    int                    gap_pct = 0;
    int                    stall_pct = 0;
    int                    lim_total = 10;
    int                    lim_b = 3;
    int                    rounds_seen = 0;

    rumor_median_counter_fsm #(.MEMBERS(MEMBERS)) dut (.*);

    rmc_rumor_checker #(.MEMBERS(MEMBERS)) checker_i (.*);

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        out_stall = ($urandom_range(99, 0) < stall_pct);
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_beat(func_t f, int m, int r, int s);
        @(negedge clk);
        while (gap_pct > 0 && $urandom_range(99, 0) < gap_pct)
        begin
            in_valid = 1'b0;
            func = func_t'($urandom_range(3, 0));
            member = MEMBER_W'($urandom);
            round = ROUND_BITS'($urandom);
            with_sender = 1'($urandom);
            @(negedge clk);
        end
        in_valid = 1'b1;
        func = f;
        member = MEMBER_W'(m);
        round = ROUND_BITS'(r);
        with_sender = 1'(s);
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        if (f == FUNC_START)
        begin
            rounds_seen = 0;
        end
        else if (f == FUNC_ADV)
        begin
            rounds_seen++;
        end
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = ROUND_BITS'(val);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic apply_limits(int t, int b, int c);
        settle();
        cfg_write(CFG_MAX_TOTAL, t);
        cfg_write(CFG_MAX_IN_B, b);
        cfg_write(CFG_MAX_IN_C, c);
        lim_total = t;
        lim_b = b;
    endtask

    function automatic int pick_member();
        return ($urandom_range(3, 0) != 0) ? $urandom_range(7, 0) : $urandom_range(63, 0);
    endfunction

    function automatic int pick_round();
        int r;
        case ($urandom_range(9, 0))
            0, 1, 2, 3, 4: r = rounds_seen - 1 + $urandom_range(3, 0);
            5, 6, 7:       r = $urandom_range(lim_b + 1, 0);
            8:             r = $urandom_range(1023, 0);
            default:       r = ($urandom_range(1, 0) != 0) ? lim_b + 1 : lim_total + 1;
        endcase
        if (r < 0)
        begin
            r = 0;
        end
        if (r > 1023)
        begin
            r = 1023;
        end
        return r;
    endfunction

    task automatic run_traffic(int count);
        int sent;
        int steps;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9, 0) == 0)
            begin
                send_beat(func_t'($urandom_range(3, 0)), $urandom_range(63, 0),
                          $urandom_range(1023, 0), $urandom_range(1, 0));
                sent++;
            end
            else
            begin
                if ($urandom_range(3, 0) == 0)
                begin
                    send_beat(FUNC_START, pick_member(), pick_round(), $urandom_range(1, 0));
                    sent++;
                end
                steps = $urandom_range(6, 0);
                repeat (steps)
                begin
                    if ($urandom_range(3, 0) == 0)
                    begin
                        send_beat(FUNC_PEER, pick_member(), $urandom_range(1023, 0),
                                  $urandom_range(1, 0));
                    end
                    else
                    begin
                        send_beat(FUNC_RECV, pick_member(), pick_round(), $urandom_range(1, 0));
                    end
                    sent++;
                end
                send_beat(FUNC_ADV, $urandom_range(63, 0), $urandom_range(1023, 0),
                          $urandom_range(1, 0));
                sent++;
            end
        end
    endtask

    initial
    begin
        int phase_no;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_beat(FUNC_ADV, 0, 0, 0);
        send_beat(FUNC_START, 0, 0, 0);
        send_beat(FUNC_RECV, 0, 0, 0);
        send_beat(FUNC_RECV, 63, 1023, 1);
        send_beat(FUNC_RECV, 63, 5, 0);
        send_beat(FUNC_PEER, 5, 0, 0);
        send_beat(FUNC_PEER, 63, 0, 0);
        send_beat(FUNC_ADV, 0, 0, 0);
        repeat (4) send_beat(FUNC_ADV, 0, 0, 0);
        send_beat(FUNC_RECV, 1, 2, 0);
        send_beat(FUNC_PEER, 2, 0, 0);
        send_beat(FUNC_START, 0, 1023, 1);
        send_beat(FUNC_START, 7, 5, 1);
        send_beat(FUNC_START, 63, 2, 1);
        send_beat(FUNC_RECV, 63, 0, 0);
        send_beat(FUNC_RECV, 1, 0, 0);
        send_beat(FUNC_ADV, 0, 0, 0);
        send_beat(FUNC_START, 42, 1023, 0);
        send_beat(FUNC_PEER, 10, 1023, 1);
        send_beat(FUNC_ADV, 63, 1023, 1);

        settle();
        cfg_write(CFG_SPARE, $urandom_range(1023, 0));

        for (phase_no = 0; phase_no < 8; phase_no++)
        begin
            case (phase_no)
                0:       apply_limits(10, 3, 3);
                1:       apply_limits(1023, 1023, 1023);
                2:       apply_limits(0, 0, 0);
                3:       apply_limits(1023, 0, 0);
                6:       apply_limits(1023, 2, 1023);
                default: apply_limits($urandom_range(40, 8), $urandom_range(8, 0),
                                      $urandom_range(6, 1));
            endcase
            case (phase_no % 4)
                0:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct = 62;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct = 62;
                end
                default:
                begin
                    gap_pct = 18;
                    stall_pct = 18;
                end
            endcase
            run_traffic(ITEMS_PER_PHASE);
        end

        // drive the total counter into saturation from the old phase
        gap_pct = 0;
        stall_pct = 0;
        apply_limits(5, 3, 3);
        send_beat(FUNC_START, 0, 1023, 1);
        repeat (SATURATE_ADVANCES)
        begin
            send_beat(FUNC_ADV, $urandom_range(63, 0), $urandom_range(1023, 0),
                      $urandom_range(1, 0));
        end

        @(negedge clk);
        in_valid = 1'b0;
        for (int w = 0; w < 100000 && pending != 0; w++)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fails == 0 && pending == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
